[src/bst_pkg.sv]
// shared types, constants and command/status bundles for the bottleneck spanning tree block
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

	// default sizes
	localparam int MAX_NODES_DEF   = 1024;
	localparam int MAX_EDGES_DEF   = 4096;
	localparam int WEIGHT_BITS_DEF = 20;

	// fixed field widths
	localparam int NODE_W   = 10;
	localparam int WEIGHT_W = 20;
	localparam int CFG_W    = 11;

	// input commands
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// result codes
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_IMPOSSIBLE = 2'd1,
		STAT_BAD        = 2'd2
	} stat_t;

	// input beat
	typedef struct packed {
		logic                command;
		logic [NODE_W-1:0]   node_a;
		logic [NODE_W-1:0]   node_b;
		logic [WEIGHT_W-1:0] weight;
	} req_beat_t;

	// result beat
	typedef struct packed {
		logic [1:0]          status;
		logic [WEIGHT_W-1:0] bottleneck_weight;
	} rsp_beat_t;

	// controller to datapath
	typedef struct packed {
		logic  load_edge;
		logic  fin_clr;
		logic  edge_rd;
		logic  k_clr;
		logic  k_inc;
		logic  n_clr;
		logic  n_inc;
		logic  init_wr;
		logic  join_clr;
		logic  cur_ld_a;
		logic  cur_ld_b;
		logic  cur_ld_par;
		logic  par_rd;
		logic  ra_ld;
		logic  rb_ld;
		logic  sz_rd;
		logic  sz_sel_b;
		logic  sa_ld;
		logic  union_wr;
		logic  srch_init;
		logic  srch_step;
		logic  out_ld;
		stat_t out_code;
		logic  out_prefix;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic base_bad;
		logic k_end;
		logic edge_bad;
		logic n_end;
		logic w_over;
		logic is_root;
		logic roots_eq;
		logic connected;
		logic at_top;
		logic bit_zero;
	} dp_stat_t;

endpackage
`default_nettype wire

[src/bst_datapath.sv]
// datapath: edge store, union-find stores, counters, threshold search and result register
`timescale 1ns / 1ps
`default_nettype none
module bst_datapath #(
	parameter int MAX_NODES   = bst_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES   = bst_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS = bst_pkg::WEIGHT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_wr_en,
	input  wire [bst_pkg::CFG_W-1:0]     cfg_wr_data,
	input  bst_pkg::req_beat_t           req,
	input  bst_pkg::dp_cmd_t             cmd,
	output bst_pkg::dp_stat_t            stat,
	output bst_pkg::rsp_beat_t           rsp
);

	localparam int NB  = $clog2(MAX_NODES);
	localparam int EB  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int TW  = $clog2(MAX_EDGES + 1);
	localparam int WB  = WEIGHT_BITS;
	localparam int BW  = $clog2(WEIGHT_BITS + 1);
	localparam int NCW = (NB + 1 > bst_pkg::CFG_W) ? NB + 1 : bst_pkg::CFG_W;
	localparam int SZW = NB + 1;
	localparam int EW  = 2 * bst_pkg::NODE_W + WB;

	// memories
	logic [EW-1:0]  edge_mem [MAX_EDGES];
	logic [NB-1:0]  par_mem  [MAX_NODES];
	logic [SZW-1:0] size_mem [MAX_NODES];

	logic [bst_pkg::CFG_W-1:0] node_count_q;
	logic [TW-1:0]             total_q;
	logic                      err_q;
	logic [TW-1:0]             k_q;
	logic [NCW-1:0]            n_q;
	logic [NCW-1:0]            joins_q;
	logic [EW-1:0]             edge_rd_q;
	logic [NB-1:0]             par_rd_q;
	logic [SZW-1:0]            size_rd_q;
	logic [NB-1:0]             cur_q;
	logic [NB-1:0]             ra_q;
	logic [NB-1:0]             rb_q;
	logic [SZW-1:0]            sa_q;
	logic [WB-1:0]             prefix_q;
	logic [BW-1:0]             bit_q;
	bst_pkg::rsp_beat_t        rsp_q;

	logic [bst_pkg::NODE_W-1:0] e_a, e_b;
	logic [WB-1:0]              e_w;
	logic [WB-1:0]              test_w;
	logic                       full;
	logic                       b_bigger;
	logic [NB-1:0]              big_idx, small_idx;
	logic [SZW-1:0]             sum_sz;

	assign e_a = edge_rd_q[EW-1 -: bst_pkg::NODE_W];
	assign e_b = edge_rd_q[WB +: bst_pkg::NODE_W];
	assign e_w = edge_rd_q[WB-1:0];
	assign test_w = prefix_q | ~({WB{1'b1}} << bit_q);
	assign full = (total_q == TW'(MAX_EDGES));
	assign b_bigger = (size_rd_q > sa_q);
	assign big_idx = b_bigger ? rb_q : ra_q;
	assign small_idx = b_bigger ? ra_q : rb_q;
	assign sum_sz = sa_q + size_rd_q;

	// status toward the controller
	always_comb begin
		stat.base_bad  = err_q || (node_count_q == '0) ||
			(32'(node_count_q) > 32'(MAX_NODES));
		stat.k_end     = (k_q == total_q);
		stat.edge_bad  = (bst_pkg::CFG_W'(e_a) >= node_count_q) ||
			(bst_pkg::CFG_W'(e_b) >= node_count_q);
		stat.n_end     = (n_q == NCW'(node_count_q));
		stat.w_over    = (e_w > test_w);
		stat.is_root   = (par_rd_q == cur_q);
		stat.roots_eq  = (ra_q == rb_q);
		stat.connected = (joins_q == NCW'(node_count_q) - NCW'(1));
		stat.at_top    = (bit_q == BW'(WB));
		stat.bit_zero  = (bit_q == '0);
	end

	// configuration register, edge count and error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= bst_pkg::CFG_W'(1);
			total_q      <= '0;
			err_q        <= 1'b0;
		end else begin
			if (cfg_wr_en)
				node_count_q <= cfg_wr_data;
			if (cmd.fin_clr) begin
				total_q <= '0;
				err_q   <= 1'b0;
			end else if (cmd.load_edge) begin
				if (full)
					err_q <= 1'b1;
				else
					total_q <= total_q + TW'(1);
			end
		end
	end

	// edge store
	always_ff @(posedge clk) begin
		if (cmd.load_edge && !full)
			edge_mem[total_q[EB-1:0]] <= {req.node_a, req.node_b, WB'(req.weight)};
		if (cmd.edge_rd)
			edge_rd_q <= edge_mem[k_q[EB-1:0]];
	end

	// parent and tree size stores
	always_ff @(posedge clk) begin
		if (cmd.init_wr) begin
			par_mem[n_q[NB-1:0]]  <= n_q[NB-1:0];
			size_mem[n_q[NB-1:0]] <= SZW'(1);
		end else if (cmd.union_wr) begin
			par_mem[small_idx]  <= big_idx;
			size_mem[big_idx]   <= sum_sz;
		end
		if (cmd.par_rd)
			par_rd_q <= par_mem[cur_q];
		if (cmd.sz_rd)
			size_rd_q <= size_mem[cmd.sz_sel_b ? rb_q : ra_q];
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			n_q     <= '0;
			joins_q <= '0;
		end else begin
			if (cmd.k_clr)
				k_q <= '0;
			else if (cmd.k_inc)
				k_q <= k_q + TW'(1);
			if (cmd.n_clr)
				n_q <= '0;
			else if (cmd.n_inc)
				n_q <= n_q + NCW'(1);
			if (cmd.join_clr)
				joins_q <= '0;
			else if (cmd.union_wr)
				joins_q <= joins_q + NCW'(1);
		end
	end

	// find walk and root registers
	always_ff @(posedge clk) begin
		if (cmd.cur_ld_a)
			cur_q <= NB'(e_a);
		else if (cmd.cur_ld_b)
			cur_q <= NB'(e_b);
		else if (cmd.cur_ld_par)
			cur_q <= par_rd_q;
		if (cmd.ra_ld)
			ra_q <= cur_q;
		if (cmd.rb_ld)
			rb_q <= cur_q;
		if (cmd.sa_ld)
			sa_q <= size_rd_q;
	end

	// threshold search, one weight bit per round from the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			bit_q    <= '0;
		end else if (cmd.srch_init) begin
			prefix_q <= '0;
			bit_q    <= BW'(WB);
		end else if (cmd.srch_step) begin
			if (!stat.connected && !stat.at_top)
				prefix_q <= prefix_q | (WB'(1) << bit_q);
			bit_q <= bit_q - BW'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			rsp_q.status            <= cmd.out_code;
			rsp_q.bottleneck_weight <= cmd.out_prefix ?
				bst_pkg::WEIGHT_W'(prefix_q) : '0;
		end
	end
	assign rsp = rsp_q;

endmodule
`default_nettype wire

[src/bst_ctrl.sv]
// controller: sequencer for load, input check, forest build rounds and result handshake
`timescale 1ns / 1ps
`default_nettype none
module bst_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  wire                 req_command,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	input  bst_pkg::dp_stat_t   stat,
	output bst_pkg::dp_cmd_t    cmd
);

	typedef enum logic [16:0] {
		S_IDLE      = 17'h00001,
		S_CK_RD     = 17'h00002,
		S_CK_EV     = 17'h00004,
		S_BAD       = 17'h00008,
		S_RND_START = 17'h00010,
		S_INIT      = 17'h00020,
		S_E_RD      = 17'h00040,
		S_E_EV      = 17'h00080,
		S_FA_RD     = 17'h00100,
		S_FA_EV     = 17'h00200,
		S_FB_RD     = 17'h00400,
		S_FB_EV     = 17'h00800,
		S_CMP       = 17'h01000,
		S_SZB       = 17'h02000,
		S_UNION     = 17'h04000,
		S_RND_END   = 17'h08000,
		S_FINAL     = 17'h10000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   req_take;
	logic   rsp_set;

	// a finish beat waits until the previous result is taken
	assign req_stall = (state_q != S_IDLE) ||
		((req_command == bst_pkg::CMD_FINISH) && rsp_valid_q);
	assign req_take = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.out_code = bst_pkg::STAT_OK;
		rsp_set = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_take) begin
					if (req_command == bst_pkg::CMD_ADD) begin
						cmd.load_edge = 1'b1;
					end else begin
						cmd.k_clr = 1'b1;
						state_d = S_CK_RD;
					end
				end
			end
			S_CK_RD: begin
				if (stat.base_bad) begin
					state_d = S_BAD;
				end else if (stat.k_end) begin
					cmd.srch_init = 1'b1;
					state_d = S_RND_START;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d = S_CK_EV;
				end
			end
			S_CK_EV: begin
				if (stat.edge_bad) begin
					state_d = S_BAD;
				end else begin
					cmd.k_inc = 1'b1;
					state_d = S_CK_RD;
				end
			end
			S_BAD: begin
				cmd.out_ld = 1'b1;
				cmd.out_code = bst_pkg::STAT_BAD;
				cmd.fin_clr = 1'b1;
				rsp_set = 1'b1;
				state_d = S_IDLE;
			end
			S_RND_START: begin
				cmd.n_clr = 1'b1;
				cmd.k_clr = 1'b1;
				cmd.join_clr = 1'b1;
				state_d = S_INIT;
			end
			S_INIT: begin
				if (stat.n_end) begin
					state_d = S_E_RD;
				end else begin
					cmd.init_wr = 1'b1;
					cmd.n_inc = 1'b1;
				end
			end
			S_E_RD: begin
				if (stat.k_end) begin
					state_d = S_RND_END;
				end else begin
					cmd.edge_rd = 1'b1;
					state_d = S_E_EV;
				end
			end
			S_E_EV: begin
				if (stat.w_over) begin
					cmd.k_inc = 1'b1;
					state_d = S_E_RD;
				end else begin
					cmd.cur_ld_a = 1'b1;
					state_d = S_FA_RD;
				end
			end
			S_FA_RD: begin
				cmd.par_rd = 1'b1;
				state_d = S_FA_EV;
			end
			S_FA_EV: begin
				if (stat.is_root) begin
					cmd.ra_ld = 1'b1;
					cmd.cur_ld_b = 1'b1;
					state_d = S_FB_RD;
				end else begin
					cmd.cur_ld_par = 1'b1;
					state_d = S_FA_RD;
				end
			end
			S_FB_RD: begin
				cmd.par_rd = 1'b1;
				state_d = S_FB_EV;
			end
			S_FB_EV: begin
				if (stat.is_root) begin
					cmd.rb_ld = 1'b1;
					state_d = S_CMP;
				end else begin
					cmd.cur_ld_par = 1'b1;
					state_d = S_FB_RD;
				end
			end
			S_CMP: begin
				if (stat.roots_eq) begin
					cmd.k_inc = 1'b1;
					state_d = S_E_RD;
				end else begin
					cmd.sz_rd = 1'b1;
					state_d = S_SZB;
				end
			end
			S_SZB: begin
				cmd.sa_ld = 1'b1;
				cmd.sz_rd = 1'b1;
				cmd.sz_sel_b = 1'b1;
				state_d = S_UNION;
			end
			S_UNION: begin
				cmd.union_wr = 1'b1;
				cmd.k_inc = 1'b1;
				state_d = S_E_RD;
			end
			S_RND_END: begin
				cmd.srch_step = 1'b1;
				if (stat.at_top && !stat.connected) begin
					cmd.out_ld = 1'b1;
					cmd.out_code = bst_pkg::STAT_IMPOSSIBLE;
					cmd.fin_clr = 1'b1;
					rsp_set = 1'b1;
					state_d = S_IDLE;
				end else if (stat.bit_zero) begin
					state_d = S_FINAL;
				end else begin
					state_d = S_RND_START;
				end
			end
			S_FINAL: begin
				cmd.out_ld = 1'b1;
				cmd.out_code = bst_pkg::STAT_OK;
				cmd.out_prefix = 1'b1;
				cmd.fin_clr = 1'b1;
				rsp_set = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_set)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

[src/bottleneck_spanning_tree.sv]
// top level: minimum bottleneck spanning tree over loaded edges
`timescale 1ns / 1ps
`default_nettype none
// Edges load one per beat (command 0) into an edge store of MAX_EDGES entries.
// A finish beat (command 1) checks the set, then finds the smallest weight
// threshold under which the edges join all node_count nodes: one union-find
// round with union by size for the all-ones threshold and then one per weight
// bit, WEIGHT_BITS + 1 rounds in all (only the first one if the graph is
// disconnected). The check tests both endpoints of every edge; each round
// resets the forest, skips each edge above the threshold, walks both ends to
// their roots and joins two trees where the roots differ. The parent hops of
// both root walks go through the single read port of the parent store.
// One result beat follows each finish: status 0 with the bottleneck weight,
// 1 if disconnected, 2 on store overflow, an endpoint outside node_count or
// a bad node_count. Adds are taken while a result waits; another finish
// waits until it is taken.
module bottleneck_spanning_tree #(
	parameter int MAX_NODES   = bst_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES   = bst_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_BITS = bst_pkg::WEIGHT_BITS_DEF
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_wr_en,
	input  wire [bst_pkg::CFG_W-1:0] cfg_wr_data,
	input  wire                      req_valid,
	output logic                     req_stall,
	input  bst_pkg::req_beat_t       req,
	output logic                     rsp_valid,
	input  wire                      rsp_stall,
	output bst_pkg::rsp_beat_t       rsp
);

	bst_pkg::dp_cmd_t  cmd;
	bst_pkg::dp_stat_t stat;

	// sequencer
	bst_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_command (req.command),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	// stores and arithmetic
	bst_datapath #(
		.MAX_NODES   (MAX_NODES),
		.MAX_EDGES   (MAX_EDGES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.cmd         (cmd),
		.stat        (stat),
		.rsp         (rsp)
	);

endmodule
`default_nettype wire
